FILE: rtl/text_line_glyph_rasterizer_assert.svh
// Assertion macros shared by the checkers of the glyph rasterizer.
// Each expects clk and arst_n in the scope where it is used.
`ifndef TEXT_LINE_GLYPH_RASTERIZER_ASSERT_SVH
`define TEXT_LINE_GLYPH_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLGR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rasterizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLGR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rasterizer check failed");

`endif

FILE: rtl/tlgr_pkg.sv
package tlgr_pkg;

	localparam int DISPLAY_WIDTH = 128;
	localparam int LINE_HEIGHT   = 16;

	localparam int GLYPH_COLS   = 5;
	localparam int GLYPH_ROWS   = 7;
	localparam int GLYPH_SCALE  = 2;
	localparam int CELL_ADVANCE = 12;
	localparam int SCALED_ROWS  = GLYPH_ROWS * GLYPH_SCALE;
	localparam int SCALED_COLS  = GLYPH_COLS * GLYPH_SCALE;
	localparam int EMIT_ROWS    = (LINE_HEIGHT < SCALED_ROWS) ? LINE_HEIGHT : SCALED_ROWS;

	localparam logic [3:0] LAST_ROW = 4'(EMIT_ROWS - 1);

	// Five columns, bit r of a column is glyph row r.
	typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

	typedef struct packed {
		logic [6:0] x_position;
		glyph_t     glyph;
	} cmd_t;

	function automatic glyph_t mk(input logic [6:0] c0, input logic [6:0] c1,
			input logic [6:0] c2, input logic [6:0] c3, input logic [6:0] c4);
		return {c4, c3, c2, c1, c0};
	endfunction

	function automatic glyph_t font_lookup(input logic [7:0] code);
		glyph_t g;
		case (code)
			"0": g = mk(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
			"1": g = mk(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
			"2": g = mk(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
			"3": g = mk(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
			"4": g = mk(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
			"5": g = mk(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
			"6": g = mk(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
			"7": g = mk(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
			"8": g = mk(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
			"9": g = mk(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
			"A": g = mk(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
			"B": g = mk(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
			"C": g = mk(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
			"D": g = mk(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
			"E": g = mk(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
			"F": g = mk(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
			"G": g = mk(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
			"I": g = mk(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
			"K": g = mk(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
			"L": g = mk(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
			"M": g = mk(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
			"N": g = mk(7'h7F, 7'h02, 7'h04, 7'h08, 7'h7F);
			"O": g = mk(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
			"P": g = mk(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
			"R": g = mk(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
			"S": g = mk(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
			"T": g = mk(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
			"U": g = mk(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
			"V": g = mk(7'h07, 7'h38, 7'h40, 7'h38, 7'h07);
			"Y": g = mk(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
			"Z": g = mk(7'h41, 7'h63, 7'h55, 7'h49, 7'h41);
			":": g = mk(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
			"-": g = mk(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
			"/": g = mk(7'h40, 7'h30, 7'h0C, 7'h03, 7'h00);
			">": g = mk(7'h08, 7'h14, 7'h22, 7'h41, 7'h00);
			default: g = '0;
		endcase
		return g;
	endfunction

	// Scaled row r shows glyph row r/2; each column covers two pixels.
	function automatic logic [SCALED_COLS-1:0] row_mask(input glyph_t g, input logic [3:0] row);
		logic [SCALED_COLS-1:0] m;
		logic [2:0]             gr;
		gr = row[3:1];
		for (int c = 0; c < GLYPH_COLS; c++) begin
			m[c*GLYPH_SCALE +: GLYPH_SCALE] = {GLYPH_SCALE{g[c][gr]}};
		end
		return m;
	endfunction

endpackage

FILE: rtl/tlgr_if.sv
interface tlgr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       line_start;

	modport source (output valid, output char_code, output line_start, input ready);
	modport sink   (input valid, input char_code, input line_start, output ready);
endinterface

interface tlgr_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] x_position;
	logic [3:0] pixel_row;
	logic [9:0] pixel_mask;
	logic       last_row;

	modport source (output valid, output x_position, output pixel_row, output pixel_mask,
		output last_row, input ready);
	modport sink   (input valid, input x_position, input pixel_row, input pixel_mask,
		input last_row, output ready);
endinterface

FILE: rtl/tlgr_front.sv
module tlgr_front (
	input  logic          clk,
	input  logic          arst_n,
	tlgr_in_if.sink       in_ch,
	output logic          push_valid,
	output tlgr_pkg::cmd_t push_cmd,
	input  logic          push_ready
);
	import tlgr_pkg::*;

	logic [7:0] cursor_q;
	logic [7:0] cur_start;
	logic       fits;
	logic       accept;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;

	assign cur_start = in_ch.line_start ? 8'd0 : cursor_q;
	assign fits      = ({1'b0, cur_start} + 9'(SCALED_COLS)) <= 9'(DISPLAY_WIDTH);

	assign push_valid          = accept && fits;
	assign push_cmd.x_position = cur_start[6:0];
	assign push_cmd.glyph      = font_lookup(in_ch.char_code);

	// Advance only when the glyph fits; a rejected glyph leaves the cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			cursor_q <= fits ? cur_start + 8'(CELL_ADVANCE) : cur_start;
		end
	end
endmodule

FILE: rtl/tlgr_queue.sv
module tlgr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  tlgr_pkg::cmd_t push_cmd,
	output logic           push_ready,
	output logic           pop_valid,
	output tlgr_pkg::cmd_t pop_cmd,
	input  logic           pop
);
	import tlgr_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

FILE: rtl/tlgr_back.sv
module tlgr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  tlgr_pkg::cmd_t pop_cmd,
	output logic           pop,
	tlgr_out_if.source     out_ch
);
	import tlgr_pkg::*;

	cmd_t       cur_q;
	logic       busy_q;
	logic [3:0] row_q;
	logic       out_valid_q;
	logic       advance;
	logic       have;
	cmd_t       src;
	logic [3:0] row;

	assign advance = !out_valid_q || out_ch.ready;
	assign have    = busy_q || pop_valid;
	assign src     = busy_q ? cur_q : pop_cmd;
	assign row     = busy_q ? row_q : 4'd0;
	assign pop     = advance && !busy_q && pop_valid;

	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have;
			if (have) begin
				busy_q <= (row != LAST_ROW);
				row_q  <= row + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && have) begin
			cur_q             <= src;
			out_ch.x_position <= src.x_position;
			out_ch.pixel_row  <= row;
			out_ch.pixel_mask <= row_mask(src.glyph, row);
			out_ch.last_row   <= (row == LAST_ROW);
		end
	end
endmodule

FILE: rtl/text_line_glyph_rasterizer.sv
// With the back end idle, a character's command is written into the command queue when
// its transaction is taken; the back end then pops it and registers its first row.
// Throughput: one row per cycle while out_ch.ready does not stall the output; a fitting
// character yields min(14, LINE_HEIGHT) rows; one that does not fit is dropped at intake.
// Reset: arst_n clears the cursor, the two-entry command queue and the output register.
module text_line_glyph_rasterizer (
	input  logic       clk,
	input  logic       arst_n,
	tlgr_in_if.sink    in_ch,
	tlgr_out_if.source out_ch
);
	import tlgr_pkg::*;

	// Front to queue
	logic push_valid;
	cmd_t push_cmd;
	logic push_ready;

	// Queue to back
	logic pop_valid;
	cmd_t pop_cmd;
	logic pop;

	// Front: hold the cursor, look up the glyph, drop characters that do not fit.
	tlgr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	// Queue: decouple intake from row generation so each side stalls on its own.
	tlgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop)
	);

	// Back: walk the scaled rows and drive the registered output transaction.
	tlgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_ch    (out_ch)
	);
endmodule

FILE: rtl/tlgr_checker.sv
`include "text_line_glyph_rasterizer_assert.svh"

module tlgr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] x_position,
	input logic [3:0] pixel_row,
	input logic       last_row
);
	import tlgr_pkg::*;

	`TLGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TLGR_ASSERT_SAME(a_last_is_final, out_valid && last_row, pixel_row == LAST_ROW)
	`TLGR_ASSERT_NEXT(a_rows_run_on, out_valid && out_ready && !last_row,
		out_valid && pixel_row == $past(pixel_row) + 4'd1)
	`TLGR_ASSERT_NEXT(a_cell_kept, out_valid && out_ready && !last_row,
		x_position == $past(x_position))
endmodule

bind text_line_glyph_rasterizer tlgr_checker u_tlgr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.x_position (out_ch.x_position),
	.pixel_row  (out_ch.pixel_row),
	.last_row   (out_ch.last_row)
);
